// ===== hdl/esalu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esalu_pkg
// shared types and codes for the elementwise saturating integer alu
// ----------------------------------------------------------------------------
package esalu_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned TYPE_W  = 3;
    localparam int unsigned CIDX_W  = 2;
    localparam int unsigned CDATA_W = 3;
    localparam int unsigned EXT_W   = DATA_W + 1;
    localparam int unsigned WIDE_W  = 2 * EXT_W;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_OP_KIND   = 2'd0;
    localparam logic [CIDX_W-1:0] REG_ELEM_TYPE = 2'd1;
    localparam logic [CIDX_W-1:0] REG_WIDEN     = 2'd2;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD = 2'd0;
    localparam logic [OP_W-1:0] OP_SUB = 2'd1;
    localparam logic [OP_W-1:0] OP_MUL = 2'd2;

    // element size codes (upper bits of the element type)
    localparam logic [1:0] SZ_8  = 2'd0;
    localparam logic [1:0] SZ_16 = 2'd1;
    localparam logic [1:0] SZ_32 = 2'd2;

    localparam logic [TYPE_W-1:0] TYPE_LAST = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]   op_kind;
        logic [TYPE_W-1:0] elem_type;
        logic              widen;
    } cfg_t;

endpackage

// ===== hdl/elementwise_saturating_alu_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elementwise_saturating_alu_unit
// element pair in, saturated or widened add/sub/mul result out
// ----------------------------------------------------------------------------
// channel   signals                          moves
// in        in_valid in_ready                operand_a operand_b
// out       out_valid out_ready              result_bits bad_mode
// cfg       cfg_we cfg_index cfg_wdata       op_kind elem_type widen
//
// one request per cycle while in_ready is high; the operand register loads at
// accept, and the result register loads from it when out is not stalled
// reset clears valid flags and sets add, u8, no widening
// a stall on out holds the result and the operand stage; in_ready drops
// only when both stages are full and out is stalled
// ----------------------------------------------------------------------------
module elementwise_saturating_alu_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [esalu_pkg::CIDX_W-1:0]      cfg_index,
    input  logic [esalu_pkg::CDATA_W-1:0]     cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [esalu_pkg::DATA_W-1:0]      operand_a,
    input  logic [esalu_pkg::DATA_W-1:0]      operand_b,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [esalu_pkg::DATA_W-1:0]      result_bits,
    output logic                              bad_mode
);

    esalu_pkg::cfg_t                  cfg_reg;
    logic [esalu_pkg::DATA_W-1:0]     a_reg;
    logic [esalu_pkg::DATA_W-1:0]     b_reg;
    logic                             s1_valid_reg;
    logic [esalu_pkg::DATA_W-1:0]     result_reg;
    logic                             bad_reg;
    logic                             out_valid_reg;
    logic [esalu_pkg::DATA_W-1:0]     result_next;
    logic                             bad_next;
    logic                             advance;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.op_kind   <= esalu_pkg::OP_ADD;
            cfg_reg.elem_type <= '0;
            cfg_reg.widen     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                esalu_pkg::REG_OP_KIND:   cfg_reg.op_kind   <= cfg_wdata[esalu_pkg::OP_W-1:0];
                esalu_pkg::REG_ELEM_TYPE: cfg_reg.elem_type <= cfg_wdata;
                esalu_pkg::REG_WIDEN:     cfg_reg.widen     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            a_reg <= operand_a;
            b_reg <= operand_b;
        end
        if (advance && s1_valid_reg)
        begin
            result_reg <= result_next;
            bad_reg    <= bad_next;
        end
    end

    esalu_core u_core (
        .cfg         (cfg_reg),
        .operand_a   (a_reg),
        .operand_b   (b_reg),
        .result_bits (result_next),
        .bad_mode    (bad_next)
    );

    assign out_valid   = out_valid_reg;
    assign result_bits = result_reg;
    assign bad_mode    = bad_reg;

`ifndef ASSERT_OFF
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_mode |-> result_bits == '0)
        else $error("bad mode result not zero");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |-> !in_ready)
        else $error("operand stage overwritten while stalled");

    a_sat_u8_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !cfg_reg.widen && cfg_reg.elem_type[2:1] == esalu_pkg::SZ_8
        |-> result_bits[31:8] == '0)
        else $error("8-bit saturated result out of range");

    a_wide_8_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cfg_reg.widen && cfg_reg.elem_type[2:1] == esalu_pkg::SZ_8
        |-> result_bits[31:16] == '0)
        else $error("8-bit widened result out of range");
`endif

endmodule

// ===== hdl/esalu_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esalu_core
// combinational add, subtract and multiply with saturation or widening
// ----------------------------------------------------------------------------
module esalu_core (
    input  esalu_pkg::cfg_t                   cfg,
    input  logic [esalu_pkg::DATA_W-1:0]      operand_a,
    input  logic [esalu_pkg::DATA_W-1:0]      operand_b,
    output logic [esalu_pkg::DATA_W-1:0]      result_bits,
    output logic                              bad_mode
);

    function automatic logic signed [esalu_pkg::EXT_W-1:0] ext_elem(
        input logic [esalu_pkg::DATA_W-1:0] raw,
        input logic [1:0]                   sz,
        input logic                         sgn
    );
        logic signed [esalu_pkg::EXT_W-1:0] v;
        unique case (sz)
            esalu_pkg::SZ_8:  v = {{25{sgn & raw[7]}}, raw[7:0]};
            esalu_pkg::SZ_16: v = {{17{sgn & raw[15]}}, raw[15:0]};
            default:          v = {sgn & raw[31], raw[31:0]};
        endcase
        return v;
    endfunction

    logic [1:0]                           sz;
    logic                                 sgn;
    logic signed [esalu_pkg::EXT_W-1:0]   a_ext;
    logic signed [esalu_pkg::EXT_W-1:0]   b_ext;
    logic signed [esalu_pkg::WIDE_W-1:0]  a_wide;
    logic signed [esalu_pkg::WIDE_W-1:0]  b_wide;
    logic signed [esalu_pkg::WIDE_W-1:0]  r;
    logic signed [esalu_pkg::WIDE_W-1:0]  hi;
    logic signed [esalu_pkg::WIDE_W-1:0]  lo;
    logic signed [esalu_pkg::WIDE_W-1:0]  clamped;
    logic [esalu_pkg::DATA_W-1:0]         sat_mask;
    logic [esalu_pkg::DATA_W-1:0]         wide_mask;

    assign sz  = cfg.elem_type[2:1];
    assign sgn = cfg.elem_type[0];

    assign bad_mode = (cfg.op_kind > esalu_pkg::OP_MUL) || (cfg.elem_type > esalu_pkg::TYPE_LAST)
                   || (cfg.widen && (sz == esalu_pkg::SZ_32));

    assign a_ext  = ext_elem(operand_a, sz, sgn);
    assign b_ext  = ext_elem(operand_b, sz, sgn);
    assign a_wide = {{esalu_pkg::EXT_W{a_ext[esalu_pkg::EXT_W-1]}}, a_ext};
    assign b_wide = {{esalu_pkg::EXT_W{b_ext[esalu_pkg::EXT_W-1]}}, b_ext};

    always_comb
    begin
        case (cfg.op_kind)
            esalu_pkg::OP_ADD: r = a_wide + b_wide;
            esalu_pkg::OP_SUB: r = a_wide - b_wide;
            default:           r = a_ext * b_ext;
        endcase
    end

    always_comb
    begin
        unique case (sz)
            esalu_pkg::SZ_8:
            begin
                sat_mask  = 32'h0000_00ff;
                wide_mask = 32'h0000_ffff;
                hi = sgn ? 66'sd127 : 66'sd255;
                lo = sgn ? -66'sd128 : 66'sd0;
            end
            esalu_pkg::SZ_16:
            begin
                sat_mask  = 32'h0000_ffff;
                wide_mask = 32'hffff_ffff;
                hi = sgn ? 66'sd32767 : 66'sd65535;
                lo = sgn ? -66'sd32768 : 66'sd0;
            end
            default:
            begin
                sat_mask  = 32'hffff_ffff;
                wide_mask = 32'hffff_ffff;
                hi = sgn ? 66'sd2147483647 : 66'sd4294967295;
                lo = sgn ? -66'sd2147483648 : 66'sd0;
            end
        endcase
    end

    always_comb
    begin
        if (r > hi)
            clamped = hi;
        else if (r < lo)
            clamped = lo;
        else
            clamped = r;
    end

    always_comb
    begin
        if (bad_mode)
            result_bits = '0;
        else if (cfg.widen)
            result_bits = r[esalu_pkg::DATA_W-1:0] & wide_mask;
        else
            result_bits = clamped[esalu_pkg::DATA_W-1:0] & sat_mask;
    end

endmodule

// ===== bench/elementwise_saturating_alu_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elementwise_saturating_alu_unit_tb
// self-checking bench for the saturating add/sub/mul element unit. a table of
// corner requests runs first, then random requests under several mode
// settings, with random gaps on the request side and random stalls on the
// result side. results are checked against the table or a bit-true prediction.
// ----------------------------------------------------------------------------
module elementwise_saturating_alu_unit_tb;

    localparam int CLK_PERIOD = 12;
    localparam int DIR_N      = 24;
    localparam int SEG_N      = 7;
    localparam int SEG_REQS   = 25;

    localparam logic [esalu_pkg::OP_W-1:0] OP_ADD = esalu_pkg::OP_ADD;
    localparam logic [esalu_pkg::OP_W-1:0] OP_SUB = esalu_pkg::OP_SUB;
    localparam logic [esalu_pkg::OP_W-1:0] OP_MUL = esalu_pkg::OP_MUL;

    localparam logic [esalu_pkg::TYPE_W-1:0] ET_U8  = 3'd0;
    localparam logic [esalu_pkg::TYPE_W-1:0] ET_S8  = 3'd1;
    localparam logic [esalu_pkg::TYPE_W-1:0] ET_U16 = 3'd2;
    localparam logic [esalu_pkg::TYPE_W-1:0] ET_S16 = 3'd3;
    localparam logic [esalu_pkg::TYPE_W-1:0] ET_U32 = 3'd4;
    localparam logic [esalu_pkg::TYPE_W-1:0] ET_S32 = 3'd5;
    localparam logic [esalu_pkg::TYPE_W-1:0] ET_BAD7 = 3'd7;
    localparam logic [esalu_pkg::OP_W-1:0]   OP_BAD  = 2'd3;
    localparam logic [esalu_pkg::CIDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [esalu_pkg::DATA_W-1:0] bits;
        logic                         bad;
    } alu_result_t;

    typedef struct packed {
        esalu_pkg::cfg_t              mode;
        logic [esalu_pkg::DATA_W-1:0] a;
        logic [esalu_pkg::DATA_W-1:0] b;
        logic                         known;
        logic [esalu_pkg::DATA_W-1:0] exp_bits;
        logic                         exp_bad;
    } vector_t;

    localparam vector_t DIR_VEC [DIR_N] = '{
        '{'{OP_ADD, ET_U8,  1'b0}, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
        '{'{OP_ADD, ET_U8,  1'b0}, 32'h0000_00FF, 32'h0000_0001, 1'b1, 32'h0000_00FF, 1'b0},
        '{'{OP_ADD, ET_U8,  1'b0}, 32'hFFFF_FF10, 32'hABCD_EF20, 1'b0, 32'h0, 1'b0},
        '{'{OP_SUB, ET_U8,  1'b0}, 32'h0000_0000, 32'h0000_0001, 1'b1, 32'h0000_0000, 1'b0},
        '{'{OP_ADD, ET_S8,  1'b0}, 32'h0000_007F, 32'h0000_0001, 1'b1, 32'h0000_007F, 1'b0},
        '{'{OP_ADD, ET_S8,  1'b0}, 32'h1234_56F0, 32'hFFFF_FF85, 1'b0, 32'h0, 1'b0},
        '{'{OP_SUB, ET_S8,  1'b0}, 32'h0000_0080, 32'h0000_0001, 1'b1, 32'h0000_0080, 1'b0},
        '{'{OP_MUL, ET_S16, 1'b0}, 32'h0000_8000, 32'h0000_8000, 1'b1, 32'h0000_7FFF, 1'b0},
        '{'{OP_MUL, ET_U16, 1'b0}, 32'h0000_FFFF, 32'h0000_FFFF, 1'b1, 32'h0000_FFFF, 1'b0},
        '{'{OP_MUL, ET_U32, 1'b0}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0},
        '{'{OP_MUL, ET_U32, 1'b0}, 32'h0001_0000, 32'h0000_FFFF, 1'b0, 32'h0, 1'b0},
        '{'{OP_MUL, ET_S32, 1'b0}, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 1'b0},
        '{'{OP_MUL, ET_S32, 1'b0}, 32'h8000_0000, 32'h0000_0001, 1'b1, 32'h8000_0000, 1'b0},
        '{'{OP_ADD, ET_S32, 1'b0}, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b0},
        '{'{OP_SUB, ET_U32, 1'b0}, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
        '{'{OP_ADD, ET_U8,  1'b1}, 32'h0000_00FF, 32'h0000_00FF, 1'b1, 32'h0000_01FE, 1'b0},
        '{'{OP_SUB, ET_U8,  1'b1}, 32'h0000_0000, 32'h0000_00FF, 1'b1, 32'h0000_FF01, 1'b0},
        '{'{OP_MUL, ET_S8,  1'b1}, 32'h0000_0080, 32'h0000_0080, 1'b1, 32'h0000_4000, 1'b0},
        '{'{OP_MUL, ET_U16, 1'b1}, 32'h0000_FFFF, 32'h0000_FFFF, 1'b1, 32'hFFFE_0001, 1'b0},
        '{'{OP_SUB, ET_S16, 1'b1}, 32'h0000_8000, 32'h0000_7FFF, 1'b1, 32'hFFFF_0001, 1'b0},
        '{'{OP_ADD, ET_S16, 1'b1}, 32'h0000_8000, 32'h0000_8000, 1'b1, 32'hFFFF_0000, 1'b0},
        '{'{OP_ADD, ET_U32, 1'b1}, 32'h0000_0001, 32'h0000_0002, 1'b1, 32'h0000_0000, 1'b1},
        '{'{OP_BAD, ET_U16, 1'b0}, 32'h0000_0001, 32'h0000_0002, 1'b1, 32'h0000_0000, 1'b1},
        '{'{OP_SUB, ET_BAD7, 1'b0}, 32'h0000_0005, 32'h0000_0003, 1'b1, 32'h0000_0000, 1'b1}
    };

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [esalu_pkg::CIDX_W-1:0]    cfg_index;
    logic [esalu_pkg::CDATA_W-1:0]   cfg_wdata;
    logic                            in_valid;
    logic                            in_ready;
    logic [esalu_pkg::DATA_W-1:0]    operand_a;
    logic [esalu_pkg::DATA_W-1:0]    operand_b;
    logic                            out_valid;
    logic                            out_ready;
    logic [esalu_pkg::DATA_W-1:0]    result_bits;
    logic                            bad_mode;

    esalu_pkg::cfg_t      mode_shadow;
    alu_result_t          pending_results [$];
    int                   err_count;
    int                   idle_pct;
    int                   stall_pct;

    elementwise_saturating_alu_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operand_a   (operand_a),
        .operand_b   (operand_b),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_bits (result_bits),
        .bad_mode    (bad_mode)
    );

    initial clk = 1'b0;
    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    function automatic alu_result_t predict_alu(esalu_pkg::cfg_t m,
                                                logic [esalu_pkg::DATA_W-1:0] a_raw,
                                                logic [esalu_pkg::DATA_W-1:0] b_raw);
        alu_result_t             res;
        int unsigned             w;
        bit                      sgn;
        logic signed [65:0]      a;
        logic signed [65:0]      b;
        logic signed [65:0]      r;
        logic signed [65:0]      hi;
        logic signed [65:0]      lo;
        logic signed [65:0]      mask;
        logic signed [65:0]      wide_mask;
        logic signed [65:0]      unit;
        res = '0;
        if (m.op_kind > esalu_pkg::OP_MUL || m.elem_type > esalu_pkg::TYPE_LAST ||
            (m.widen && m.elem_type[2:1] == esalu_pkg::SZ_32))
        begin
            res.bad = 1'b1;
            return res;
        end
        w    = 8 << m.elem_type[2:1];
        sgn  = m.elem_type[0];
        unit = 66'sd1;
        mask = (unit <<< w) - unit;
        a = {34'd0, a_raw};
        b = {34'd0, b_raw};
        a = a & mask;
        b = b & mask;
        if (sgn && a[w-1])
            a = a - (unit <<< w);
        if (sgn && b[w-1])
            b = b - (unit <<< w);
        case (m.op_kind)
            esalu_pkg::OP_ADD: r = a + b;
            esalu_pkg::OP_SUB: r = a - b;
            default:           r = a * b;
        endcase
        if (m.widen)
        begin
            wide_mask = (unit <<< (2 * w)) - unit;
            r = r & wide_mask;
            res.bits = r[esalu_pkg::DATA_W-1:0];
        end
        else
        begin
            if (sgn)
            begin
                hi = (unit <<< (w - 1)) - unit;
                lo = -(unit <<< (w - 1));
            end
            else
            begin
                hi = mask;
                lo = '0;
            end
            if (r > hi)
                r = hi;
            if (r < lo)
                r = lo;
            r = r & mask;
            res.bits = r[esalu_pkg::DATA_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [esalu_pkg::DATA_W-1:0] boundary_value();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_007F;
            2:       return 32'h0000_0080;
            3:       return 32'h0000_00FF;
            4:       return 32'h0000_7FFF;
            5:       return 32'h0000_8000;
            6:       return 32'h0000_FFFF;
            7:       return 32'h7FFF_FFFF;
            8:       return 32'h8000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [esalu_pkg::DATA_W-1:0] pick_operand();
        logic [esalu_pkg::DATA_W-1:0] v;
        case ($urandom_range(0, 7))
            0, 1, 2: v = $urandom;
            3:       v = $urandom_range(0, 3);
            4:       v = 32'h0 - $urandom_range(0, 3);
            5:       v = boundary_value();
            default: v = boundary_value() ^ ($urandom & 32'hFFFF_0000);
        endcase
        return v;
    endfunction

    // result side: random stalls and in-order compare
    always @(posedge clk)
    begin
        alu_result_t want;
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result bits=%h bad=%b", $time, result_bits, bad_mode);
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_bits !== want.bits)
                begin
                    $display("%0t: result_bits expected %h actual %h",
                             $time, want.bits, result_bits);
                    err_count++;
                end
                if (bad_mode !== want.bad)
                begin
                    $display("%0t: bad_mode expected %b actual %b",
                             $time, want.bad, bad_mode);
                    err_count++;
                end
            end
        end
    end

    task automatic send_request(logic [esalu_pkg::DATA_W-1:0] a,
                                logic [esalu_pkg::DATA_W-1:0] b,
                                alu_result_t want);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(want);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_mode(logic [esalu_pkg::CDATA_W-1:0] op_raw,
                                logic [esalu_pkg::CDATA_W-1:0] type_raw,
                                logic [esalu_pkg::CDATA_W-1:0] widen_raw, bit touch_spare);
        cfg_we    <= 1'b1;
        cfg_index <= esalu_pkg::REG_OP_KIND;
        cfg_wdata <= op_raw;
        @(posedge clk);
        cfg_index <= esalu_pkg::REG_ELEM_TYPE;
        cfg_wdata <= type_raw;
        @(posedge clk);
        cfg_index <= esalu_pkg::REG_WIDEN;
        cfg_wdata <= widen_raw;
        @(posedge clk);
        if (touch_spare)
        begin
            cfg_index <= REG_SPARE;
            cfg_wdata <= 3'($urandom_range(0, 7));
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        mode_shadow.op_kind   = op_raw[esalu_pkg::OP_W-1:0];
        mode_shadow.elem_type = type_raw;
        mode_shadow.widen     = widen_raw[0];
    endtask

    initial
    begin
        vector_t                       vec;
        alu_result_t                   want;
        logic [esalu_pkg::DATA_W-1:0]  a;
        logic [esalu_pkg::DATA_W-1:0]  b;
        logic [esalu_pkg::CDATA_W-1:0] op_raw;
        logic [esalu_pkg::CDATA_W-1:0] type_raw;
        err_count   = 0;
        idle_pct    = 0;
        stall_pct   = 0;
        mode_shadow = '{OP_ADD, ET_U8, 1'b0};
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        in_valid    = 1'b0;
        operand_a   = '0;
        operand_b   = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner table, first row runs on the reset mode
        for (int i = 0; i < DIR_N; i++)
        begin
            vec = DIR_VEC[i];
            if (vec.mode != mode_shadow)
            begin
                wait_drained();
                program_mode({1'b0, vec.mode.op_kind}, vec.mode.elem_type,
                             {2'b00, vec.mode.widen}, 1'b0);
            end
            if (vec.known)
                want = '{vec.exp_bits, vec.exp_bad};
            else
                want = predict_alu(mode_shadow, vec.a, vec.b);
            send_request(vec.a, vec.b, want);
        end

        // random part: flow-control phases, each over several mode settings
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 75; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 75; end
                default: begin idle_pct = 33; stall_pct = 33; end
            endcase
            for (int s = 0; s < SEG_N; s++)
            begin
                wait_drained();
                op_raw   = 3'($urandom_range(0, 7));
                type_raw = 3'($urandom_range(0, 7));
                if ($urandom_range(0, 9) != 0)
                begin
                    op_raw[1:0] = 2'($urandom_range(0, 2));
                    type_raw    = 3'($urandom_range(0, 5));
                end
                program_mode(op_raw, type_raw, 3'($urandom_range(0, 7)),
                             $urandom_range(0, 3) == 0);
                for (int k = 0; k < SEG_REQS; k++)
                begin
                    a = pick_operand();
                    b = pick_operand();
                    send_request(a, b, predict_alu(mode_shadow, a, b));
                end
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (err_count == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #(CLK_PERIOD * 400000);
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/esalu_pkg.sv
hdl/esalu_core.sv
hdl/elementwise_saturating_alu_unit.sv
bench/elementwise_saturating_alu_unit_tb.sv
